@@ design/baas_pkg.sv @@
// ----------------------------------------------------------------------------
// Block ack scoreboard package
// Shared widths, constants, command and register codes, and the request
// structure that runs between the control logic and the fragment store.
// ----------------------------------------------------------------------------
package baas_pkg;

  // Sizing of the window and the stores.
  localparam int WINDOW_SIZE      = 64;
  localparam int SEQ_MODULUS      = 4096;
  localparam int FRAGS_PER_PACKET = 16;
  localparam int STORE_DEPTH      = 64;

  // Field widths.
  localparam int CMD_W      = 3;
  localparam int SEQ_W      = 12;
  localparam int FRAG_NUM_W = 4;
  localparam int SLOT_W     = $clog2(STORE_DEPTH);
  localparam int OFF_W      = $clog2(SEQ_MODULUS);
  localparam int FRAG_W     = FRAGS_PER_PACKET;
  localparam int WORD_W     = 64;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ = 2'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_MARK_PKT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MARK_FRAG  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY_PKT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_FRAG = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

  // Access request to the fragment store.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [FRAG_W-1:0] wr_data;
    logic              clear;
  } store_req_t;

endpackage

@@ design/baas_if.sv @@
// ----------------------------------------------------------------------------
// Block ack scoreboard channels
// Valid/ready channels for command words, result words and register writes.
// ----------------------------------------------------------------------------
interface baas_in_if;
  import baas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [SEQ_W-1:0]      seq_num;
  logic [FRAG_NUM_W-1:0] frag_num;
  logic [SLOT_W-1:0]     word_index;

  modport source (output valid, command, seq_num, frag_num, word_index, input ready);
  modport sink (input valid, command, seq_num, frag_num, word_index, output ready);
endinterface

interface baas_out_if;
  import baas_pkg::*;

  logic              valid;
  logic              ready;
  logic              received;
  logic              in_window;
  logic [WORD_W-1:0] bitmap_word;

  modport source (output valid, received, in_window, bitmap_word, input ready);
  modport sink (input valid, received, in_window, bitmap_word, output ready);
endinterface

interface baas_cfg_if;
  import baas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/baas_frag_store.sv @@
// ----------------------------------------------------------------------------
// Fragment bitmap store
// Synchronous memory of fragment words with a registered read port. A
// valid bit per entry lets a clear reset all entries at once: an entry
// that has not been written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module baas_frag_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  baas_pkg::store_req_t        req_i,
  output logic [baas_pkg::FRAG_W-1:0] rd_data_o
);
  import baas_pkg::*;

  logic [FRAG_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_q;
  logic [FRAG_W-1:0]      rd_data_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

  // The controller never reads and writes back in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en))
    else $error("fragment store read and write overlap");

  // A write makes its entry valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en && !req_i.clear |=> valid_q[$past(req_i.wr_addr)])
    else $error("written entry not marked valid");

  // A cleared or never written entry reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd_en && !valid_q[req_i.rd_addr] |=> rd_data_o == '0)
    else $error("invalid entry read as nonzero");

endmodule

@@ design/block_ack_bitmap_scoreboard_unit.sv @@
// ----------------------------------------------------------------------------
// Block ack bitmap scoreboard
// Receive-side scoreboard for a 64-entry block ack window, basic and
// compressed bitmaps.
// ----------------------------------------------------------------------------
// For each command word, in the cycle it is accepted the window offset is
// computed and the fragment memory is read, and in the execute state the
// entry is updated and written back and the result word is loaded into the
// output register. A new command is taken once the result is in the output
// register; a stalled output holds the execute state until the previous
// result is taken. A clear command finishes within its execute state, since
// the fragment memory is tracked by per-entry valid bits and the compressed
// bitmap is a register. Register writes are taken at any time but must only
// be issued while the block is idle.
module block_ack_bitmap_scoreboard_unit (
  input  logic clk_i,
  input  logic rst_ni,
  baas_in_if.sink    in_i,
  baas_out_if.source out_o,
  baas_cfg_if.sink   cfg_i
);
  import baas_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e                state_q;
  logic                  ack_mode_q;
  logic [SEQ_W-1:0]      start_seq_q;
  logic [STORE_DEPTH-1:0] comp_q;
  logic [STORE_DEPTH-1:0] comp_d;

  // Command held between accept and update.
  logic [CMD_W-1:0]      cmd_q;
  logic [FRAG_NUM_W-1:0] frag_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  inwin_q;

  // Output register.
  logic              out_valid_q;
  logic              received_q, received_d;
  logic              in_window_q, in_window_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic              in_fire, done;
  logic [OFF_W-1:0]  offset;
  logic              inwin;
  logic [SLOT_W-1:0] slot;
  logic              frag_ok;
  logic [FRAG_W-1:0] frag_mask;
  logic [FRAG_W-1:0] rd_data;
  logic              wr_en;
  logic [FRAG_W-1:0] wr_data;
  store_req_t        store_req;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign done        = (state_q == ST_EXEC) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  // Window offset, modulo the sequence space.
  assign offset = OFF_W'(in_i.seq_num - start_seq_q);
  assign inwin  = int'(offset) < WINDOW_SIZE;
  assign slot   = offset[SLOT_W-1:0];

  assign frag_ok   = int'(frag_q) < FRAGS_PER_PACKET;
  assign frag_mask = FRAG_W'(1) << frag_q;

  always_comb begin
    received_d  = 1'b0;
    in_window_d = 1'b0;
    word_d      = '0;
    wr_en       = 1'b0;
    wr_data     = rd_data;
    comp_d      = comp_q;
    unique case (cmd_q)
      CMD_MARK_PKT: begin
        in_window_d = inwin_q;
        if (inwin_q) begin
          if (ack_mode_q) begin
            comp_d[slot_q] = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_data = rd_data | FRAG_W'(1);
          end
        end
      end
      CMD_MARK_FRAG: begin
        in_window_d = inwin_q;
        if (inwin_q && !ack_mode_q && frag_ok) begin
          wr_en   = 1'b1;
          wr_data = rd_data | frag_mask;
        end
      end
      CMD_QUERY_PKT: begin
        in_window_d = inwin_q;
        received_d  = inwin_q && ack_mode_q && comp_q[slot_q];
      end
      CMD_QUERY_FRAG: begin
        in_window_d = inwin_q;
        if (inwin_q) begin
          if (ack_mode_q) begin
            received_d = comp_q[slot_q];
          end else begin
            received_d = frag_ok && |(rd_data & frag_mask);
          end
        end
      end
      CMD_CLEAR: begin
        comp_d = '0;
      end
      CMD_READ: begin
        word_d = ack_mode_q ? WORD_W'(comp_q) : WORD_W'(rd_data);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    store_req.rd_en   = in_fire;
    store_req.rd_addr = (in_i.command == CMD_READ) ? in_i.word_index : slot;
    store_req.wr_en   = done && wr_en;
    store_req.wr_addr = slot_q;
    store_req.wr_data = wr_data;
    store_req.clear   = done && (cmd_q == CMD_CLEAR);
  end

  baas_frag_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      comp_q      <= '0;
    end else begin
      if (out_o.ready && !done) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            comp_q      <= comp_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_mode_q  <= 1'b0;
      start_seq_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ACK_MODE:  ack_mode_q  <= cfg_i.data[0];
        CFG_START_SEQ: start_seq_q <= cfg_i.data[SEQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= in_i.command;
      frag_q  <= in_i.frag_num;
      slot_q  <= slot;
      inwin_q <= inwin;
    end
    if (done) begin
      received_q  <= received_d;
      in_window_q <= in_window_d;
      word_q      <= word_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.received    = received_q;
  assign out_o.in_window   = in_window_q;
  assign out_o.bitmap_word = word_q;

  // A result word holds steady until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.received)
      && $stable(out_o.in_window) && $stable(out_o.bitmap_word))
    else $error("result word changed while stalled");

  // A command word is not taken while another one is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("command taken while busy");

  // Every finished command leaves a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_o.valid)
    else $error("finished command left no result word");

endmodule
